FILE: rtl/tcws_pkg.sv
package tcws_pkg;

   localparam int SCREEN_HEIGHT = 480;
   localparam int TEX_W_BITS = 6;
   localparam int TEX_H_BITS = 6;
   localparam int ADDR_W = 14;
   localparam int COLOR_W = 24;
   localparam int LH_W = 16;
   localparam int NUM_W = 24;
   localparam int QUO_W = 22;
   localparam int PROD_W = 41;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_RENDER = 1'b1
   } tcws_cmd_type;

   typedef enum logic [1:0] {
      CSR_CEILING = 2'd0,
      CSR_FLOOR = 2'd1,
      CSR_VIEWER_X = 2'd2,
      CSR_VIEWER_Y = 2'd3
   } tcws_csr_type;

   typedef enum logic [1:0] {
      SEL_FLOOR = 2'd0,
      SEL_CEILING = 2'd1,
      SEL_TEXTURE = 2'd2
   } tcws_sel_type;

   typedef struct packed {
      logic cmd;
      logic [9:0] column;
      logic [8:0] row;
      logic [8:0] wall_top;
      logic [8:0] wall_bottom;
      logic [15:0] slice_height;
      logic hit_side;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [23:0] wall_distance;
      logic [13:0] texel_address;
      logic [23:0] texel_value;
   } tcws_req_type;

   typedef struct packed {
      logic [9:0] out_column;
      logic [8:0] out_row;
      logic [23:0] pixel_color;
   } tcws_rsp_type;

   typedef struct packed {
      logic cmd;
      logic neg;
      tcws_sel_type sel;
      logic [1:0] tex;
      logic [TEX_W_BITS-1:0] tcol;
      logic [9:0] column;
      logic [8:0] row;
      logic [ADDR_W-1:0] taddr;
      logic [COLOR_W-1:0] tvalue;
   } tcws_side_type;

endpackage

FILE: rtl/tcws_div.sv
module tcws_div (
   input logic clock,
   input logic reset,
   input logic en,
   input logic in_valid,
   input logic [tcws_pkg::QUO_W-1:0] numer,
   input logic [tcws_pkg::LH_W-1:0] denom,
   input tcws_pkg::tcws_side_type in_side,
   output logic out_valid,
   output logic [tcws_pkg::QUO_W-1:0] quot,
   output tcws_pkg::tcws_side_type out_side
);
   import tcws_pkg::*;

   logic valid_ff [0:QUO_W];
   logic [LH_W-1:0] rem_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic [LH_W-1:0] den_ff [0:QUO_W];
   tcws_side_type side_ff [0:QUO_W];
   logic [LH_W-1:0] rem_in [1:QUO_W];
   logic [QUO_W-1:0] quo_in [1:QUO_W];

   // one quotient bit per stage, msb first
   always_comb begin
      logic [LH_W:0] t;
      for (int j = 1; j <= QUO_W; j++) begin
         t = {rem_ff[j-1], quo_ff[j-1][QUO_W-1]};
         if (t >= {1'b0, den_ff[j-1]}) begin
            rem_in[j] = LH_W'(t - {1'b0, den_ff[j-1]});
            quo_in[j] = {quo_ff[j-1][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[j] = t[LH_W-1:0];
            quo_in[j] = {quo_ff[j-1][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QUO_W; j++) valid_ff[j] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int j = 1; j <= QUO_W; j++) valid_ff[j] <= valid_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         quo_ff[0] <= numer;
         den_ff[0] <= denom;
         side_ff[0] <= in_side;
         for (int j = 1; j <= QUO_W; j++) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= den_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign quot = quo_ff[QUO_W];
   assign out_side = side_ff[QUO_W];

endmodule

FILE: rtl/textured_wall_column_shader_unit.sv
// Raycaster wall column shader, one pixel per word.
// req channel (valid/ready): a write word (cmd 0) stores texel_value at
// texel_address in the 16384-entry texel memory and gives no result; a
// render word (cmd 1) gives one rsp word with the column, the row and the
// pixel colour (ceiling, floor or a texel of one of four wall textures).
// csr port: write enable, index and data set the ceiling and floor colours
// and the viewer position; write it only while no words are in flight.
// Throughput: one word per cycle while no valid rsp waits untaken. From req
// acceptance to rsp valid a word passes the hit multiply and fraction stages, a
// 22-stage restoring divider for the texture row (one quotient bit per
// stage), the address stage and the registered texel memory read.
// Words leave in the order they enter, so a render reads texels written by
// earlier write words.
// The whole pipeline advances together: while rsp is valid and not taken,
// every stage holds and req_ready is low; nothing is lost or repeated.
// Reset empties the pipeline and clears the csr registers; the texel memory
// is not cleared and must be written before it is read.
module textured_wall_column_shader_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input tcws_pkg::tcws_req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output tcws_pkg::tcws_rsp_type rsp_data,
   input logic csr_write_enable,
   input logic [1:0] csr_index,
   input logic [23:0] csr_data
);
   import tcws_pkg::*;

   logic [COLOR_W-1:0] ceiling_ff, floor_ff, viewer_x_ff, viewer_y_ff;
   logic en;

   // stage 1
   logic s1_valid_ff;
   logic signed [PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic [COLOR_W-1:0] s1_pos_ff, s1_pos_in;
   logic signed [NUM_W-1:0] s1_num_ff, s1_num_in;
   logic [LH_W-1:0] s1_den_ff, s1_den_in;
   logic s1_mirror_ff, s1_mirror_in;
   tcws_side_type s1_side_ff, s1_side_in;

   // stage 2
   logic s2_valid_ff;
   logic [QUO_W-1:0] s2_numer_ff, s2_numer_in;
   logic [LH_W-1:0] s2_den_ff;
   tcws_side_type s2_side_ff, s2_side_in;

   logic div_valid;
   logic [QUO_W-1:0] div_quot;
   tcws_side_type div_side;

   // stage 3
   logic s3_valid_ff;
   logic [ADDR_W-1:0] s3_idx_ff, s3_idx_in;
   tcws_side_type s3_side_ff;

   // output stage
   logic [COLOR_W-1:0] texel_mem [0:(1<<ADDR_W)-1];
   logic [COLOR_W-1:0] rdata_ff;
   logic [COLOR_W-1:0] flat_ff;
   tcws_sel_type sel_ff;
   logic [9:0] col_ff;
   logic [8:0] row_ff;
   logic rsp_valid_ff;

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= '0;
         floor_ff <= '0;
         viewer_x_ff <= '0;
         viewer_y_ff <= '0;
      end else if (csr_write_enable) begin
         case (tcws_csr_type'(csr_index))
            CSR_CEILING: ceiling_ff <= csr_data;
            CSR_FLOOR: floor_ff <= csr_data;
            CSR_VIEWER_X: viewer_x_ff <= csr_data;
            CSR_VIEWER_Y: viewer_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic signed [15:0] dir;
      logic signed [17:0] base;
      dir = req_data.hit_side ? req_data.dir_x : req_data.dir_y;
      s1_pos_in = req_data.hit_side ? viewer_x_ff : viewer_y_ff;
      s1_prod_in = PROD_W'($signed({1'b0, req_data.wall_distance})) * PROD_W'(dir);
      s1_den_in = (req_data.slice_height == '0) ? LH_W'(1) : req_data.slice_height;
      base = $signed({9'b0, req_data.row}) - 18'(SCREEN_HEIGHT / 2)
         + $signed({3'b0, s1_den_in[LH_W-1:1]});
      s1_num_in = NUM_W'(base) <<< TEX_H_BITS;
      s1_mirror_in = req_data.hit_side ? req_data.dir_y[15]
         : (!req_data.dir_x[15] && req_data.dir_x != '0);
      s1_side_in.cmd = req_data.cmd;
      s1_side_in.neg = 1'b0;
      if (req_data.row > req_data.wall_bottom) s1_side_in.sel = SEL_FLOOR;
      else if (req_data.row < req_data.wall_top) s1_side_in.sel = SEL_CEILING;
      else s1_side_in.sel = SEL_TEXTURE;
      s1_side_in.tex = req_data.hit_side ? {1'b0, req_data.dir_y[15]}
         : {1'b1, req_data.dir_x[15]};
      s1_side_in.tcol = '0;
      s1_side_in.column = req_data.column;
      s1_side_in.row = req_data.row;
      s1_side_in.taddr = req_data.texel_address;
      s1_side_in.tvalue = req_data.texel_value;
   end

   always_comb begin
      logic [PROD_W-1:0] hit;
      logic signed [NUM_W-1:0] a;
      hit = {3'b0, s1_pos_ff, 14'b0} + s1_prod_ff;
      s2_side_in = s1_side_ff;
      s2_side_in.tcol = s1_mirror_ff ? ~hit[29 -: TEX_W_BITS] : hit[29 -: TEX_W_BITS];
      s2_side_in.neg = s1_num_ff[NUM_W-1];
      // floor of a negative quotient from the ceiling of its magnitude
      a = s1_num_ff[NUM_W-1]
         ? -s1_num_ff + $signed({8'b0, s1_den_ff}) - NUM_W'(1) : s1_num_ff;
      s2_numer_in = a[QUO_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= div_valid;
         rsp_valid_ff <= s3_valid_ff && s3_side_ff.cmd == CMD_RENDER;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= s1_prod_in;
         s1_pos_ff <= s1_pos_in;
         s1_num_ff <= s1_num_in;
         s1_den_ff <= s1_den_in;
         s1_mirror_ff <= s1_mirror_in;
         s1_side_ff <= s1_side_in;
         s2_numer_ff <= s2_numer_in;
         s2_den_ff <= s1_den_ff;
         s2_side_ff <= s2_side_in;
         s3_idx_ff <= s3_idx_in;
         s3_side_ff <= div_side;
      end
   end

   tcws_div u_div (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(s2_valid_ff),
      .numer(s2_numer_ff),
      .denom(s2_den_ff),
      .in_side(s2_side_ff),
      .out_valid(div_valid),
      .quot(div_quot),
      .out_side(div_side)
   );

   always_comb begin
      logic [TEX_H_BITS-1:0] trow;
      trow = div_side.neg ? -div_quot[TEX_H_BITS-1:0] : div_quot[TEX_H_BITS-1:0];
      s3_idx_in = {div_side.tex, trow, div_side.tcol};
   end

   always_ff @(posedge clock) begin
      if (en && s3_valid_ff && s3_side_ff.cmd == CMD_WRITE) begin
         texel_mem[s3_side_ff.taddr] <= s3_side_ff.tvalue;
      end
      if (en) begin
         rdata_ff <= texel_mem[s3_idx_ff];
         flat_ff <= (s3_side_ff.sel == SEL_FLOOR) ? floor_ff : ceiling_ff;
         sel_ff <= s3_side_ff.sel;
         col_ff <= s3_side_ff.column;
         row_ff <= s3_side_ff.row;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.out_column = col_ff;
   assign rsp_data.out_row = row_ff;
   assign rsp_data.pixel_color = (sel_ff == SEL_TEXTURE) ? rdata_ff : flat_ff;

`ifndef SYNTHESIS
   a_ready_follows_output: assert property (@(posedge clock)
      req_ready == (!rsp_valid_ff || rsp_ready))
      else $error("req_ready does not follow output stall");
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff && !s3_valid_ff)
      else $error("pipeline not empty after reset");
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (en && s3_valid_ff && s3_side_ff.cmd == CMD_WRITE) |=> !rsp_valid_ff)
      else $error("write word produced a result");
`endif

endmodule
